FILE: hdl/stack_machine_alu_defines.svh
// Assertion macros for the stack machine execution unit.
// Included by the top level only; no other dependencies.
`ifndef STACK_MACHINE_ALU_DEFINES_SVH
`define STACK_MACHINE_ALU_DEFINES_SVH

// Check cons in the same cycle whenever ante holds.
`define SMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sma_pkg.sv
// Shared types, codes and the microcode program of the stack machine unit.
// No dependencies; used by every module of the block but sma_ram.
package sma_pkg;

    localparam int WORD_W          = 32;
    localparam int SMA_STACK_DEPTH = 256;
    localparam int UPC_W           = 5;

    // Operation codes
    localparam logic [2:0] MODE_PUSH  = 3'd0;
    localparam logic [2:0] MODE_POP   = 3'd1;
    localparam logic [2:0] MODE_ADD   = 3'd2;
    localparam logic [2:0] MODE_SUB   = 3'd3;
    localparam logic [2:0] MODE_MUL   = 3'd4;
    localparam logic [2:0] MODE_DIV   = 3'd5;
    localparam logic [2:0] MODE_PRINT = 3'd6;
    localparam logic [2:0] MODE_HALT  = 3'd7;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_DIV0  = 2'd2;
    localparam logic [1:0] ERR_OVER  = 2'd3;

    // Control word field codes
    localparam logic       RD_TOP   = 1'b0;
    localparam logic       RD_SEC   = 1'b1;
    localparam logic       WA_CNT   = 1'b0;
    localparam logic       WA_SEC   = 1'b1;
    localparam logic [1:0] WS_PUSH  = 2'd0;
    localparam logic [1:0] WS_ALU   = 2'd1;
    localparam logic [1:0] WS_DIV   = 2'd2;
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] J_NONE   = 2'd0;
    localparam logic [1:0] J_BZERO  = 2'd1;
    localparam logic [1:0] J_BUSY   = 2'd2;

    // Microcode addresses
    localparam logic [UPC_W-1:0] U_PUSH  = 5'd0;
    localparam logic [UPC_W-1:0] U_POP   = 5'd1;
    localparam logic [UPC_W-1:0] U_PRT0  = 5'd2;
    localparam logic [UPC_W-1:0] U_PRT1  = 5'd3;
    localparam logic [UPC_W-1:0] U_AR0   = 5'd4;
    localparam logic [UPC_W-1:0] U_AR1   = 5'd5;
    localparam logic [UPC_W-1:0] U_AR2   = 5'd6;
    localparam logic [UPC_W-1:0] U_AR3   = 5'd7;
    localparam logic [UPC_W-1:0] U_DV0   = 5'd8;
    localparam logic [UPC_W-1:0] U_DV1   = 5'd9;
    localparam logic [UPC_W-1:0] U_DV2   = 5'd10;
    localparam logic [UPC_W-1:0] U_DV3   = 5'd11;
    localparam logic [UPC_W-1:0] U_DV4   = 5'd12;
    localparam logic [UPC_W-1:0] U_DV5   = 5'd13;
    localparam logic [UPC_W-1:0] U_DV6   = 5'd14;
    localparam logic [UPC_W-1:0] U_DVZ   = 5'd15;
    localparam logic [UPC_W-1:0] U_STOP  = 5'd16;
    localparam logic [UPC_W-1:0] U_HALT  = 5'd17;
    localparam logic [UPC_W-1:0] U_UNDER = 5'd18;
    localparam logic [UPC_W-1:0] U_OVER  = 5'd19;

    typedef struct packed {
        logic [2:0]        mode;
        logic signed [31:0] push_value;
    } t_sma_req;

    typedef struct packed {
        logic signed [31:0] print_value;
        logic               print_valid;
        logic               running;
        logic [1:0]         error_code;
    } t_sma_rsp;

    // One control word of the microprogram
    typedef struct packed {
        logic             rd;
        logic             rd_sel;
        logic             ld_a;
        logic             ld_b;
        logic             wr;
        logic [1:0]       wr_src;
        logic             wr_at;
        logic [1:0]       cnt_op;
        logic             div_go;
        logic             pr;
        logic             clr_run;
        logic [1:0]       err;
        logic             done;
        logic [1:0]       jcond;
        logic [UPC_W-1:0] jtgt;
    } t_sma_uword;

    // Stack status seen by the dispatcher
    typedef struct packed {
        logic run;
        logic empty;
        logic lt2;
        logic full;
    } t_sma_flags;

    // Branch and handoff conditions seen by the sequencer
    typedef struct packed {
        logic b_zero;
        logic div_busy;
        logic rsp_free;
    } t_sma_cond;

    // Microprogram ROM
    function automatic t_sma_uword sma_ucode(input logic [UPC_W-1:0] upc);
        t_sma_uword w;
        w = '0;
        case (upc)
            U_PUSH: begin
                w.wr = 1'b1; w.wr_src = WS_PUSH; w.wr_at = WA_CNT;
                w.cnt_op = CNT_INC; w.done = 1'b1;
            end
            U_POP: begin
                w.cnt_op = CNT_DEC; w.done = 1'b1;
            end
            U_PRT0: begin
                w.rd = 1'b1; w.rd_sel = RD_TOP;
            end
            U_PRT1: begin
                w.pr = 1'b1; w.cnt_op = CNT_DEC; w.done = 1'b1;
            end
            U_AR0, U_DV0: begin
                w.rd = 1'b1; w.rd_sel = RD_TOP;
            end
            U_AR1, U_DV1: begin
                w.ld_b = 1'b1; w.rd = 1'b1; w.rd_sel = RD_SEC;
            end
            U_AR2, U_DV2: begin
                w.ld_a = 1'b1;
            end
            U_AR3: begin
                w.wr = 1'b1; w.wr_src = WS_ALU; w.wr_at = WA_SEC;
                w.cnt_op = CNT_DEC; w.done = 1'b1;
            end
            U_DV3: begin
                w.jcond = J_BZERO; w.jtgt = U_DVZ;
            end
            U_DV4: begin
                w.div_go = 1'b1;
            end
            U_DV5: begin
                w.jcond = J_BUSY; w.jtgt = U_DV5;
            end
            U_DV6: begin
                w.wr = 1'b1; w.wr_src = WS_DIV; w.wr_at = WA_SEC;
                w.cnt_op = CNT_DEC; w.done = 1'b1;
            end
            U_DVZ: begin
                w.clr_run = 1'b1; w.err = ERR_DIV0; w.done = 1'b1;
            end
            U_HALT: begin
                w.clr_run = 1'b1; w.done = 1'b1;
            end
            U_UNDER: begin
                w.clr_run = 1'b1; w.err = ERR_UNDER; w.done = 1'b1;
            end
            U_OVER: begin
                w.clr_run = 1'b1; w.err = ERR_OVER; w.done = 1'b1;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/sma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/sma_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sma_pkg for the word width.
module sma_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sma_pkg::WORD_W-1:0] i_dividend,
    input  logic [sma_pkg::WORD_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [sma_pkg::WORD_W-1:0] o_quot
);
    import sma_pkg::*;

    localparam int LW = $clog2(WORD_W);

    logic              r_busy;
    logic [LW-1:0]     r_left;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_d;
    logic              r_neg;
    logic [WORD_W:0]   trial;
    logic              fits;
    logic [WORD_W:0]   diff;

    // One restoring step: shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_q[WORD_W-1]};
    assign fits  = (trial >= {1'b0, r_d});
    assign diff  = trial - {1'b0, r_d};

    // Control: iteration count and busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_left <= LW'(WORD_W - 1);
        end else if (r_busy) begin
            if (r_left == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_left <= r_left - LW'(1);
            end
        end
    end

    // Datapath: load magnitudes, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[WORD_W-1] ? (WORD_W'(0) - i_dividend) : i_dividend;
            r_d   <= i_divisor[WORD_W-1] ? (WORD_W'(0) - i_divisor) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[WORD_W-2:0], fits};
            r_rem <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? (WORD_W'(0) - r_q) : r_q;
endmodule

FILE: hdl/sma_seq.sv
// Microcode sequencer: dispatch on accepted requests, step counter, jumps.
// Depends on sma_pkg for the control word, the program and the codes.
module sma_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_mode,
    input  sma_pkg::t_sma_flags i_flags,
    input  sma_pkg::t_sma_cond  i_cond,
    output logic                o_busy,
    output logic                o_go,
    output sma_pkg::t_sma_uword o_uword
);
    import sma_pkg::*;

    logic             r_busy;
    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] entry;
    logic             taken;
    t_sma_uword       uw;

    // Pick the program entry for a new request
    always_comb begin
        entry = U_STOP;
        if (i_flags.run) begin
            case (i_mode)
                MODE_PUSH:              entry = i_flags.full  ? U_OVER  : U_PUSH;
                MODE_POP:               entry = i_flags.empty ? U_UNDER : U_POP;
                MODE_PRINT:             entry = i_flags.empty ? U_UNDER : U_PRT0;
                MODE_HALT:              entry = U_HALT;
                MODE_DIV:               entry = i_flags.lt2   ? U_UNDER : U_DV0;
                MODE_ADD, MODE_SUB,
                MODE_MUL:               entry = i_flags.lt2   ? U_UNDER : U_AR0;
                default:                entry = U_STOP;
            endcase
        end
    end

    assign uw = sma_ucode(r_upc);

    // Jump condition
    always_comb begin
        case (uw.jcond)
            J_BZERO: taken = i_cond.b_zero;
            J_BUSY:  taken = i_cond.div_busy;
            default: taken = 1'b0;
        endcase
    end

    // The final step waits until the response register can take the result
    assign o_go = r_busy && (!uw.done || i_cond.rsp_free);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= U_STOP;
        end else if (i_accept) begin
            r_busy <= 1'b1;
            r_upc  <= entry;
        end else if (o_go) begin
            if (uw.done) begin
                r_busy <= 1'b0;
            end else begin
                r_upc <= taken ? uw.jtgt : (r_upc + UPC_W'(1));
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_uword = uw;
endmodule

FILE: hdl/stack_machine_alu.sv
// Stack machine execution unit: top level with stack datapath and handshakes.
// Depends on sma_pkg, sma_seq, sma_ram, sma_div and the assertion macros header.
`include "stack_machine_alu_defines.svh"

// One request is in flight at a time; the request channel stalls from acceptance
// until its result is loaded into the response register, which then waits for the
// consumer while the next request is taken. Push, pop, halt, underflow, overflow and
// a stopped machine go straight to the final step; print reads the top word, then
// returns it; add, sub and mul read the top and second words through the read port
// of the stack RAM, whose read data is registered, then write the result; div reads
// the same way, ends with an error on a zero divisor, else starts the radix-2 divider
// (one quotient bit per cycle), waits for it and writes the quotient. The request
// channel opens again in the cycle after the load; a full response register holds
// back the final step while the consumer stalls. The stack is a RAM of STACK_DEPTH
// words that is never cleared; only entries below the stack count are ever read.
module stack_machine_alu #(
    parameter int STACK_DEPTH = sma_pkg::SMA_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  sma_pkg::t_sma_req i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output sma_pkg::t_sma_rsp o_rsp
);
    import sma_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic              r_run;
    logic [CW-1:0]     r_cnt;
    logic [2:0]        r_mode;
    logic [WORD_W-1:0] r_pval;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic              r_rsp_valid;
    t_sma_rsp          r_rsp;

    logic              accept;
    logic              seq_busy;
    logic              go;
    t_sma_uword        uw;
    t_sma_flags        flags;
    t_sma_cond         cond;
    logic              div_busy;
    logic [WORD_W-1:0] div_quot;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] alu_res;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     addr_top;
    logic [AW-1:0]     addr_sec;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              rsp_free;

    assign accept      = i_req_valid && !o_req_stall;
    assign o_req_stall = seq_busy;
    assign rsp_free    = !r_rsp_valid || !i_rsp_stall;

    assign flags.run   = r_run;
    assign flags.empty = (r_cnt == '0);
    assign flags.lt2   = (r_cnt < CW'(2));
    assign flags.full  = (r_cnt == CW'(STACK_DEPTH));

    assign cond.b_zero   = (r_b == '0);
    assign cond.div_busy = div_busy;
    assign cond.rsp_free = rsp_free;

    sma_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_mode  (i_req.mode),
        .i_flags (flags),
        .i_cond  (cond),
        .o_busy  (seq_busy),
        .o_go    (go),
        .o_uword (uw)
    );

    // Stack addresses
    assign addr_top = AW'(r_cnt - CW'(1));
    assign addr_sec = AW'(r_cnt - CW'(2));
    assign rd_addr  = (uw.rd_sel == RD_SEC) ? addr_sec : addr_top;
    assign wr_addr  = (uw.wr_at == WA_SEC) ? addr_sec : AW'(r_cnt);

    // Arithmetic on the two top words, second op top
    always_comb begin
        case (r_mode)
            MODE_ADD: alu_res = r_a + r_b;
            MODE_SUB: alu_res = r_a - r_b;
            MODE_MUL: alu_res = WORD_W'(r_a * r_b);
            default:  alu_res = '0;
        endcase
    end

    // Write data select
    always_comb begin
        case (uw.wr_src)
            WS_PUSH: wr_data = r_pval;
            WS_ALU:  wr_data = alu_res;
            WS_DIV:  wr_data = div_quot;
            default: wr_data = '0;
        endcase
    end

    sma_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (go && uw.wr),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (go && uw.rd),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    sma_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (go && uw.div_go),
        .i_dividend(r_a),
        .i_divisor (r_b),
        .o_busy    (div_busy),
        .o_quot    (div_quot)
    );

    // Capture the request and the operands
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_req.mode;
            r_pval <= i_req.push_value;
        end
        if (go && uw.ld_a) begin
            r_a <= rd_data;
        end
        if (go && uw.ld_b) begin
            r_b <= rd_data;
        end
    end

    // Stack count and run flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_run <= 1'b1;
        end else if (go) begin
            case (uw.cnt_op)
                CNT_INC: r_cnt <= r_cnt + CW'(1);
                CNT_DEC: r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
            if (uw.clr_run) begin
                r_run <= 1'b0;
            end
        end
    end

    // Response register: load on the final step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (go && uw.done) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && uw.done) begin
            r_rsp.print_value <= uw.pr ? rd_data : '0;
            r_rsp.print_valid <= uw.pr;
            r_rsp.running     <= r_run && !uw.clr_run;
            r_rsp.error_code  <= uw.err;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Checks
    `SMA_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(STACK_DEPTH), "stack count above depth")
    `SMA_ASSERT_NEXT(a_run_sticky, i_clk, i_rst_n, !r_run, !r_run, "run flag set again without reset")
    `SMA_ASSERT_NOW(a_div_owned, i_clk, i_rst_n, div_busy, seq_busy, "divider busy while sequencer idle")
    `SMA_ASSERT_NOW(a_print_clean, i_clk, i_rst_n, r_rsp_valid && r_rsp.print_valid, (r_rsp.error_code == ERR_NONE) && r_rsp.running, "print result with error or stop")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for stack_machine_alu: drives request streams over the
// valid/stall handshake and checks each response against its own stack model.
// Depends on sma_pkg for the request and response types and the operation codes.
module testbench;
    import sma_pkg::*;

    localparam int STACK_DEPTH    = SMA_STACK_DEPTH;
    localparam int RANDOM_OPS     = 1150;
    localparam int FILL_AT        = 575;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 250;
    localparam int DRAIN_CYCLES   = 80;
    localparam int STOPPED_OPS    = 12;
    localparam int WATCHDOG_LIMIT = 4000;

    // How the run is brought to a stop
    typedef enum int {
        END_HALT,
        END_POP_EMPTY,
        END_PRINT_EMPTY,
        END_SHORT_ARITH,
        END_DIV_ZERO,
        END_OVERFLOW
    } t_ending;

    typedef struct packed {
        logic [STACK_DEPTH-1:0][WORD_W-1:0] words;
        logic [8:0]                         depth;
        logic                               running;
    } t_machine;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_req_valid = 1'b0;
    logic     i_rsp_stall = 1'b0;
    t_sma_req i_req       = '0;
    logic     o_req_stall;
    logic     o_rsp_valid;
    t_sma_rsp o_rsp;

    t_sma_req program_ops[$];
    t_sma_rsp predicted_results[$];
    t_machine planned_machine;
    t_machine machine;
    t_ending  ending;
    t_sma_rsp oldest;
    int       total_reqs   = 0;
    int       reqs_offered = 0;
    int       reqs_taken   = 0;
    int       rsps_seen    = 0;
    int       failures     = 0;
    int       idle_cycles  = 0;
    int       hold_left    = 0;
    bit       hold_done    = 1'b0;

    stack_machine_alu u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one request to a stack machine and return the response it gives
    function automatic t_sma_rsp execute_op(inout t_machine m, input t_sma_req req);
        t_sma_rsp    rsp;
        logic [31:0] a, b, amag, bmag, qmag, res;
        logic [1:0]  err;
        int          top;
        rsp = '0;
        err = ERR_NONE;
        res = '0;
        top = int'(m.depth) - 1;
        if (m.running) begin
            case (req.mode)
                MODE_PUSH: begin
                    if (m.depth < STACK_DEPTH) begin
                        m.words[m.depth] = req.push_value;
                        m.depth++;
                    end else begin
                        err = ERR_OVER;
                    end
                end
                MODE_POP, MODE_PRINT: begin
                    if (m.depth != 0) begin
                        if (req.mode == MODE_PRINT) begin
                            rsp.print_value = m.words[top];
                            rsp.print_valid = 1'b1;
                        end
                        m.depth--;
                    end else begin
                        err = ERR_UNDER;
                    end
                end
                MODE_HALT: begin
                    m.running = 1'b0;
                end
                default: begin
                    if (m.depth < 2) begin
                        err = ERR_UNDER;
                    end else begin
                        b = m.words[top];
                        a = m.words[top-1];
                        case (req.mode)
                            MODE_ADD: res = a + b;
                            MODE_SUB: res = a - b;
                            MODE_MUL: res = a * b;
                            default: begin
                                // Divide magnitudes, then restore the sign (truncates to zero)
                                if (b == 0) begin
                                    err = ERR_DIV0;
                                end else begin
                                    amag = a[31] ? -a : a;
                                    bmag = b[31] ? -b : b;
                                    qmag = amag / bmag;
                                    res  = (a[31] != b[31]) ? -qmag : qmag;
                                end
                            end
                        endcase
                        if (err == ERR_NONE) begin
                            m.words[top-1] = res;
                            m.depth--;
                        end
                    end
                end
            endcase
            if (err != ERR_NONE) m.running = 1'b0;
        end
        rsp.running    = m.running;
        rsp.error_code = err;
        return rsp;
    endfunction

    // Operand value biased toward the corners of the signed range
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(3);
            4: return 32'd0 - $urandom_range(100);
            5: return $urandom_range(1000);
            default: return $urandom();
        endcase
    endfunction

    // Three idling phases over the run: first, second, then none
    function automatic int idle_pct(input int count, input int first, input int second);
        if (count < total_reqs / 3) return first;
        if (count < 2 * total_reqs / 3) return second;
        return 0;
    endfunction

    // Queue one request and advance the planning copy of the machine
    task automatic queue_op(input logic [2:0] mode, input logic [31:0] value);
        t_sma_req req;
        t_sma_rsp unused;
        req.mode       = mode;
        req.push_value = value;
        program_ops.push_back(req);
        unused = execute_op(planned_machine, req);
    endtask

    // Pick an operation that keeps the machine running
    task automatic queue_random_op();
        logic [2:0] mode;
        int         depth;
        int         push_pct;
        depth    = planned_machine.depth;
        push_pct = (depth < 3) ? 65 : ((depth > 40) ? 30 : 48);
        if (depth == 0 || (depth < STACK_DEPTH && $urandom_range(99) < push_pct)) begin
            mode = MODE_PUSH;
        end else begin
            mode = 3'($urandom_range(MODE_POP, MODE_PRINT));
            if (depth < 2 && mode != MODE_POP) mode = MODE_PRINT;
            if (mode == MODE_DIV && planned_machine.words[depth-1] == 0) mode = MODE_PRINT;
        end
        queue_op(mode, pick_word());
    endtask

    task automatic fill_stack();
        while (planned_machine.depth < STACK_DEPTH) queue_op(MODE_PUSH, pick_word());
    endtask

    task automatic drain_stack();
        while (planned_machine.depth != 0)
            queue_op($urandom_range(1) ? MODE_PRINT : MODE_POP, $urandom());
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            failures++;
        end
    endfunction

    // Request driver: offer the next pending op, hold it until taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_req_valid || reqs_taken == reqs_offered) begin
                if (program_ops.size() != 0 &&
                    $urandom_range(99) >= idle_pct(reqs_offered, 12, 77)) begin
                    i_req       <= program_ops.pop_front();
                    i_req_valid <= 1'b1;
                    reqs_offered++;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // Response stall: random idling plus one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_rsp_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && rsps_seen >= HOLD_AT) begin
            i_rsp_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
        end else begin
            i_rsp_stall <= ($urandom_range(99) < idle_pct(rsps_seen, 77, 12));
        end
    end

    // Monitor: check responses, predict on accepted requests, watch for hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall) begin
                rsps_seen++;
                if (predicted_results.size() == 0) begin
                    $error("response with no request outstanding: %h", o_rsp);
                    failures++;
                end else begin
                    oldest = predicted_results.pop_front();
                    check_field("print_value", oldest.print_value, o_rsp.print_value);
                    check_field("print_valid", oldest.print_valid, o_rsp.print_valid);
                    check_field("running", oldest.running, o_rsp.running);
                    check_field("error_code", oldest.error_code, o_rsp.error_code);
                end
            end
            if (i_req_valid && !o_req_stall) begin
                predicted_results.push_back(execute_op(machine, i_req));
                reqs_taken++;
            end
            if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        planned_machine         = '0;
        planned_machine.running = 1'b1;
        machine                 = planned_machine;

        // Directed: add of the two extremes, most negative over minus one, signed division,
        // wrapping multiply, subtract, print of corners and of zero
        queue_op(MODE_PUSH, 32'h7FFF_FFFF);
        queue_op(MODE_PUSH, 32'h8000_0000);
        queue_op(MODE_ADD, 32'hFFFF_FFFF);
        queue_op(MODE_PUSH, 32'h8000_0000);
        queue_op(MODE_PUSH, 32'hFFFF_FFFF);
        queue_op(MODE_DIV, 32'h0000_0000);
        queue_op(MODE_PRINT, 32'h5555_5555);
        queue_op(MODE_PUSH, 32'hFFFF_FFF9);
        queue_op(MODE_PUSH, 32'h0000_0002);
        queue_op(MODE_DIV, 32'hAAAA_AAAA);
        queue_op(MODE_PUSH, 32'h7FFF_FFFF);
        queue_op(MODE_PUSH, 32'h7FFF_FFFF);
        queue_op(MODE_MUL, 32'h0000_0000);
        queue_op(MODE_PUSH, 32'h0000_0000);
        queue_op(MODE_SUB, 32'hFFFF_FFFF);
        queue_op(MODE_PUSH, 32'h8000_0000);
        queue_op(MODE_SUB, 32'h0000_0000);
        queue_op(MODE_PRINT, 32'h0000_0000);
        queue_op(MODE_POP, 32'hFFFF_FFFF);
        queue_op(MODE_PRINT, 32'h0000_0000);
        queue_op(MODE_PUSH, 32'h0000_0000);
        queue_op(MODE_PRINT, 32'hFFFF_FFFF);

        // Random well-formed ops, with one trip up to a full stack
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == FILL_AT) fill_stack();
            queue_random_op();
        end

        // Stop the machine one way, then show it ignores what follows
        ending = t_ending'($urandom_range(int'(END_HALT), int'(END_OVERFLOW)));
        case (ending)
            END_HALT: begin
                queue_op(MODE_HALT, pick_word());
            end
            END_POP_EMPTY: begin
                drain_stack();
                queue_op(MODE_POP, pick_word());
            end
            END_PRINT_EMPTY: begin
                drain_stack();
                queue_op(MODE_PRINT, pick_word());
            end
            END_SHORT_ARITH: begin
                // A zero divisor on a one-word stack still reports underflow
                drain_stack();
                if ($urandom_range(1)) queue_op(MODE_PUSH, 32'h0000_0000);
                queue_op(3'($urandom_range(MODE_ADD, MODE_DIV)), pick_word());
            end
            END_DIV_ZERO: begin
                if (planned_machine.depth == 0) queue_op(MODE_PUSH, pick_word());
                queue_op(MODE_PUSH, 32'h0000_0000);
                queue_op(MODE_DIV, pick_word());
            end
            default: begin
                fill_stack();
                queue_op(MODE_PUSH, pick_word());
            end
        endcase
        repeat (STOPPED_OPS) queue_op(3'($urandom_range(MODE_PUSH, MODE_HALT)), $urandom());
        total_reqs = program_ops.size();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_taken < total_reqs || predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
